>>> sv/gbtm_pkg.sv
// Shared constants, types and helpers for the Gaussian blur threshold mask block.
`timescale 1ns / 1ps
`default_nettype none

package gbtm_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COL_W     = ADDR_W + 1;

    // Field widths
    localparam int DIM_W   = 12;
    localparam int ROW_W   = DIM_W + 1;
    localparam int LIMIT_W = 9;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;

    // Queue between the front and back parts
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_LIMIT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_LIMIT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_LIMIT   = 3'd4;

    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [LIMIT_W-1:0] RST_RED_LIMIT    = 9'd230;
    localparam logic [LIMIT_W-1:0] RST_GREEN_LIMIT  = 9'd230;
    localparam logic [LIMIT_W-1:0] RST_BLUE_LIMIT   = 9'd180;

    // One window column: three rows, each a packed red/green/blue pixel
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } gbtm_col_t;

    // Which taps take part, and where the result sits in the frame
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic use_left;
        logic use_new;
        logic row_end;
        logic frame_end;
    } gbtm_flags_t;

    // One queued word: the three columns of a window plus its flags
    typedef struct packed {
        gbtm_col_t   left;
        gbtm_col_t   center;
        gbtm_col_t   newest;
        gbtm_flags_t flags;
    } gbtm_entry_t;

    // Width as used: zero acts as one, larger than the line store acts as its size
    function automatic logic [COL_W-1:0] clamp_width(input logic [DIM_W-1:0] width);
        if (width == '0)
            return COL_W'(1);
        else if (int'(width) > MAX_WIDTH)
            return COL_W'(MAX_WIDTH);
        else
            return COL_W'(width);
    endfunction

    // Height as used: zero acts as one
    function automatic logic [DIM_W-1:0] clamp_height(input logic [DIM_W-1:0] height);
        if (height == '0)
            return DIM_W'(1);
        else
            return height;
    endfunction

endpackage

`default_nettype wire

>>> sv/gbtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gbtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/gbtm_front.sv
// Front part: raster position tracking, line store access and window build.
`timescale 1ns / 1ps
`default_nettype none

module gbtm_front
    import gbtm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [CH_W-1:0]       red,
    input  wire logic [CH_W-1:0]       green,
    input  wire logic [CH_W-1:0]       blue,
    input  wire logic                  flush,
    input  wire logic [DIM_W-1:0]      image_width,
    input  wire logic [DIM_W-1:0]      image_height,
    input  wire logic [FIFO_CNT_W-1:0] fifo_count,
    output logic                       fifo_push,
    output gbtm_entry_t                fifo_entry
);

    // Raster position of the next word
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Stage B: the word whose line store data arrives this cycle
    logic               b_valid_reg, b_valid_next;
    logic               b_emit_reg;
    logic               b_fwd_reg;
    logic [ADDR_W-1:0]  b_addr_reg;
    logic [PIX_W-1:0]   b_pix_reg;
    logic [2*PIX_W-1:0] b_fwd_data_reg;
    gbtm_flags_t        b_flags_reg;

    // Window: newest built column and the one before it
    gbtm_col_t win_center_reg;
    gbtm_col_t win_left_reg;

    logic               accept;
    logic [COL_W-1:0]   w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic               wrap;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic               col_nz;
    logic               row_ok;
    logic [ROW_W-1:0]   out_row;
    logic               emit;
    logic               frame_done;
    gbtm_flags_t        flags_a;
    logic [PIX_W-1:0]   pix_a;
    logic [ADDR_W-1:0]  rd_addr;
    logic               fwd_hit;
    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] line;
    logic [2*PIX_W-1:0] wr_data;
    gbtm_col_t          new_col;
    logic               b_pushing;
    logic [FIFO_CNT_W:0] pending;

    // Hold off the sender once the queue could overflow
    assign b_pushing = b_valid_reg && b_emit_reg;
    assign pending   = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, b_pushing};
    assign full      = (pending >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign accept    = push && !full;

    // Classify the incoming word by its raster position
    always_comb
    begin
        w_eff   = clamp_width(image_width);
        h_eff   = {1'b0, clamp_height(image_height)};
        wrap    = (col_reg >= w_eff);
        cur_col = wrap ? '0 : col_reg;
        cur_row = wrap ? (row_reg + ROW_W'(1)) : row_reg;
        col_nz  = (cur_col != '0);

        if (col_nz)
        begin
            row_ok  = (cur_row >= ROW_W'(1));
            out_row = cur_row - ROW_W'(1);
        end
        else
        begin
            row_ok  = (cur_row >= ROW_W'(2));
            out_row = cur_row - ROW_W'(2);
        end
        emit = row_ok && (out_row < h_eff);

        flags_a.top_ok    = (out_row != '0);
        flags_a.bot_ok    = ((out_row + ROW_W'(1)) < h_eff);
        flags_a.use_left  = (cur_col >= COL_W'(2)) || (!col_nz && (w_eff >= COL_W'(2)));
        flags_a.use_new   = col_nz;
        flags_a.row_end   = !col_nz;
        flags_a.frame_end = !col_nz && (out_row == (h_eff - ROW_W'(1)));

        frame_done = !col_nz && (cur_row >= (h_eff + ROW_W'(1)));

        pix_a   = flush ? '0 : {red, green, blue};
        rd_addr = cur_col[ADDR_W-1:0];
        fwd_hit = b_valid_reg && (rd_addr == b_addr_reg);
    end

    // Advance the raster position on each accepted word
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        b_valid_next = accept;
        if (accept)
        begin
            if (frame_done)
            begin
                col_next = '0;
                row_next = '0;
            end
            else
            begin
                col_next = cur_col + COL_W'(1);
                row_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Capture the word for stage B; bypass the line store when stage B
    // writes the entry being read in the same cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_emit_reg     <= emit;
            b_fwd_reg      <= fwd_hit;
            b_addr_reg     <= rd_addr;
            b_pix_reg      <= pix_a;
            b_flags_reg    <= flags_a;
            b_fwd_data_reg <= wr_data;
        end
    end

    // Build the new column from both line stores and the current pixel
    always_comb
    begin
        line           = b_fwd_reg ? b_fwd_data_reg : ram_rdata;
        new_col.top    = line[2*PIX_W-1:PIX_W];
        new_col.mid    = line[PIX_W-1:0];
        new_col.bot    = b_pix_reg;
        wr_data        = {new_col.mid, b_pix_reg};

        fifo_push         = b_pushing;
        fifo_entry.left   = win_left_reg;
        fifo_entry.center = win_center_reg;
        fifo_entry.newest = new_col;
        fifo_entry.flags  = b_flags_reg;
    end

    // Shift the window by one column per word
    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            win_left_reg   <= win_center_reg;
            win_center_reg <= new_col;
        end
    end

    // Older line in the upper half, newer line in the lower half
    gbtm_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_addr_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("front pushed into a full queue");

    a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        b_fwd_reg && $past(accept) |-> b_valid_reg)
        else $error("bypass set without a word in stage B");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(MAX_WIDTH))
        else $error("column position beyond the line store");

endmodule

`default_nettype wire

>>> sv/gbtm_fifo.sv
// Short queue of window words between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module gbtm_fifo
    import gbtm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire gbtm_entry_t           push_entry,
    input  wire logic                  pop,
    output gbtm_entry_t                head,
    output logic [FIFO_CNT_W-1:0]      count
);

    gbtm_entry_t               slots [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]     count_reg, count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + FIFO_PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + FIFO_PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = slots[rd_ptr_reg];
    assign count = count_reg;

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> sv/gbtm_back.sv
// Back part: weighted 3x3 sum per channel, divide by 16, threshold, result register.
`timescale 1ns / 1ps
`default_nettype none

module gbtm_back
    import gbtm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [FIFO_CNT_W-1:0] fifo_count,
    input  wire gbtm_entry_t           head,
    output logic                       fifo_pop,
    input  wire logic [LIMIT_W-1:0]    red_limit,
    input  wire logic [LIMIT_W-1:0]    green_limit,
    input  wire logic [LIMIT_W-1:0]    blue_limit,
    input  wire logic                  pop,
    output logic                       empty,
    output logic                       mask,
    output logic                       row_end,
    output logic                       frame_end
);

    localparam int VSUM_W = CH_W + 2;
    localparam int SUM_W  = CH_W + 4;

    logic out_valid_reg, out_valid_next;
    logic mask_reg, row_end_reg, frame_end_reg;
    logic mask_next;
    logic take;

    logic [VSUM_W-1:0] v_left   [3];
    logic [VSUM_W-1:0] v_center [3];
    logic [VSUM_W-1:0] v_new    [3];
    logic [SUM_W-1:0]  total    [3];
    logic [CH_W-1:0]   blur     [3];

    // Vertical 1-2-1 sum of one channel of one column; skipped rows add nothing
    function automatic logic [VSUM_W-1:0] col_sum(
        input logic [CH_W-1:0] t,
        input logic [CH_W-1:0] m,
        input logic [CH_W-1:0] b,
        input logic            top_ok,
        input logic            bot_ok
    );
        logic [VSUM_W-1:0] s;
        s = {1'b0, m, 1'b0};
        if (top_ok)
            s = s + {2'b00, t};
        if (bot_ok)
            s = s + {2'b00, b};
        return s;
    endfunction

    // Blur each channel and compare against its limit
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            v_left[k]   = col_sum(head.left.top[(2-k)*CH_W +: CH_W],
                                  head.left.mid[(2-k)*CH_W +: CH_W],
                                  head.left.bot[(2-k)*CH_W +: CH_W],
                                  head.flags.top_ok, head.flags.bot_ok);
            v_center[k] = col_sum(head.center.top[(2-k)*CH_W +: CH_W],
                                  head.center.mid[(2-k)*CH_W +: CH_W],
                                  head.center.bot[(2-k)*CH_W +: CH_W],
                                  head.flags.top_ok, head.flags.bot_ok);
            v_new[k]    = col_sum(head.newest.top[(2-k)*CH_W +: CH_W],
                                  head.newest.mid[(2-k)*CH_W +: CH_W],
                                  head.newest.bot[(2-k)*CH_W +: CH_W],
                                  head.flags.top_ok, head.flags.bot_ok);
            total[k] = {1'b0, v_center[k], 1'b0}
                     + (head.flags.use_left ? {2'b00, v_left[k]} : '0)
                     + (head.flags.use_new ? {2'b00, v_new[k]} : '0);
            blur[k]  = total[k][SUM_W-1:4];
        end
        mask_next = ({1'b0, blur[0]} < red_limit)
                 && ({1'b0, blur[1]} < green_limit)
                 && ({1'b0, blur[2]} < blue_limit);
    end

    // Take a word whenever the result register is free or being drained
    assign take     = (fifo_count != '0) && (!out_valid_reg || pop);
    assign fifo_pop = take;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mask_reg      <= mask_next;
            row_end_reg   <= head.flags.row_end;
            frame_end_reg <= head.flags.frame_end;
        end
    end

    assign empty     = !out_valid_reg;
    assign mask      = mask_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

    a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> row_end_reg)
        else $error("frame end without row end");

endmodule

`default_nettype wire

>>> sv/gaussian_blur_threshold_mask.sv
// Top level: 3x3 Gaussian blur of an RGB raster stream with per-channel threshold mask.
//
// Input queue: drive red/green/blue/flush with push; a word is taken when push is
// high and full is low. One pixel a clock is sustained while full stays low. After
// the last pixel of a frame send image_width+1 words with flush high to drain it.
// Result queue: while empty is low, mask/row_end/frame_end show the oldest result;
// pop high with empty low takes it. A result appears image_width+1 input words after
// the pixel it is centered on; a word that yields a result passes the line store stage,
// the queue and the result register. One result a clock is sustained while pop is high.
// Configuration: cfg_index/cfg_data with cfg_valid; cfg_ready is always high. Write
// only while no words are in flight.
// Reset: position counters clear, registers load 640x480 and limits 230/230/180.
// Line store contents are not cleared; no pass runs after reset.
// Stall: the result register holds while pop is low, a four-word queue behind it
// fills, and full rises once the queue plus the word in the line store stage
// reach four.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_threshold_mask
    import gbtm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [CH_W-1:0]        red,
    input  wire logic [CH_W-1:0]        green,
    input  wire logic [CH_W-1:0]        blue,
    input  wire logic                   flush,
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        mask,
    output logic                        row_end,
    output logic                        frame_end,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [DIM_W-1:0]   image_width_reg, image_width_next;
    logic [DIM_W-1:0]   image_height_reg, image_height_next;
    logic [LIMIT_W-1:0] red_limit_reg, red_limit_next;
    logic [LIMIT_W-1:0] green_limit_reg, green_limit_next;
    logic [LIMIT_W-1:0] blue_limit_reg, blue_limit_next;

    logic                  cfg_write;
    logic                  fifo_push;
    logic                  fifo_pop;
    gbtm_entry_t           fifo_entry;
    gbtm_entry_t           fifo_head;
    logic [FIFO_CNT_W-1:0] fifo_count;

    // Decode configuration writes
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        red_limit_next    = red_limit_reg;
        green_limit_next  = green_limit_reg;
        blue_limit_next   = blue_limit_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_next  = cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_next = cfg_data[DIM_W-1:0];
                REG_RED_LIMIT:    red_limit_next    = cfg_data[LIMIT_W-1:0];
                REG_GREEN_LIMIT:  green_limit_next  = cfg_data[LIMIT_W-1:0];
                REG_BLUE_LIMIT:   blue_limit_next   = cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            red_limit_reg    <= RST_RED_LIMIT;
            green_limit_reg  <= RST_GREEN_LIMIT;
            blue_limit_reg   <= RST_BLUE_LIMIT;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            red_limit_reg    <= red_limit_next;
            green_limit_reg  <= green_limit_next;
            blue_limit_reg   <= blue_limit_next;
        end
    end

    gbtm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .flush        (flush),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .fifo_count   (fifo_count),
        .fifo_push    (fifo_push),
        .fifo_entry   (fifo_entry)
    );

    gbtm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fifo_push),
        .push_entry (fifo_entry),
        .pop        (fifo_pop),
        .head       (fifo_head),
        .count      (fifo_count)
    );

    gbtm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_count  (fifo_count),
        .head        (fifo_head),
        .fifo_pop    (fifo_pop),
        .red_limit   (red_limit_reg),
        .green_limit (green_limit_reg),
        .blue_limit  (blue_limit_reg),
        .pop         (pop),
        .empty       (empty),
        .mask        (mask),
        .row_end     (row_end),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire

>>> verif/tb_gaussian_blur_threshold_mask.sv
// Self-checking testbench for the Gaussian blur threshold mask block.
`timescale 1ns / 1ps

// One result word as the block presents it
typedef struct packed {
    logic mask;
    logic row_end;
    logic frame_end;
} mask_word_t;

// Blur and threshold predictor plus the store of masks still to come
class blur_mask_scoreboard;
    logic [gbtm_pkg::DIM_W-1:0]   width_reg;
    logic [gbtm_pkg::DIM_W-1:0]   height_reg;
    logic [gbtm_pkg::LIMIT_W-1:0] red_lim;
    logic [gbtm_pkg::LIMIT_W-1:0] green_lim;
    logic [gbtm_pkg::LIMIT_W-1:0] blue_lim;
    logic [gbtm_pkg::PIX_W-1:0]   older_line [gbtm_pkg::MAX_WIDTH];
    logic [gbtm_pkg::PIX_W-1:0]   newer_line [gbtm_pkg::MAX_WIDTH];
    gbtm_pkg::gbtm_col_t          last_col;
    gbtm_pkg::gbtm_col_t          prev_col;
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    int unsigned                  sum_r;
    int unsigned                  sum_g;
    int unsigned                  sum_b;
    mask_word_t                   expected_masks [$];
    int                           mismatches;

    function new();
        width_reg  = gbtm_pkg::RST_IMAGE_WIDTH;
        height_reg = gbtm_pkg::RST_IMAGE_HEIGHT;
        red_lim    = gbtm_pkg::RST_RED_LIMIT;
        green_lim  = gbtm_pkg::RST_GREEN_LIMIT;
        blue_lim   = gbtm_pkg::RST_BLUE_LIMIT;
        foreach (older_line[i])
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        last_col   = '0;
        prev_col   = '0;
        col_pos    = 0;
        row_pos    = 0;
        mismatches = 0;
    endfunction

    function void write_reg(input logic [gbtm_pkg::CFG_INDEX_W-1:0] index,
                            input logic [gbtm_pkg::CFG_DATA_W-1:0] data);
        case (index)
            gbtm_pkg::REG_IMAGE_WIDTH:  width_reg  = data;
            gbtm_pkg::REG_IMAGE_HEIGHT: height_reg = data;
            gbtm_pkg::REG_RED_LIMIT:    red_lim    = data[gbtm_pkg::LIMIT_W-1:0];
            gbtm_pkg::REG_GREEN_LIMIT:  green_lim  = data[gbtm_pkg::LIMIT_W-1:0];
            gbtm_pkg::REG_BLUE_LIMIT:   blue_lim   = data[gbtm_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_masks.size();
    endfunction

    // Add one window column: rows weighted 1,2,1 (outer rows only inside the image)
    function void add_column(input gbtm_pkg::gbtm_col_t col, input int unsigned hw,
                             input bit top_ok, input bit bot_ok);
        logic [gbtm_pkg::PIX_W-1:0] rows [3];
        int unsigned                vw [3];
        rows[0] = col.top;
        rows[1] = col.mid;
        rows[2] = col.bot;
        vw[0]   = top_ok ? hw : 0;
        vw[1]   = 2 * hw;
        vw[2]   = bot_ok ? hw : 0;
        for (int i = 0; i < 3; i++)
        begin
            sum_r += rows[i][23:16] * vw[i];
            sum_g += rows[i][15:8] * vw[i];
            sum_b += rows[i][7:0] * vw[i];
        end
    endfunction

    // Advance the raster position by one accepted word and queue its mask, if any
    function void take_pixel(input logic [7:0] red_in, input logic [7:0] green_in,
                             input logic [7:0] blue_in, input logic flush_in);
        int unsigned         w;
        int unsigned         h;
        int unsigned         c;
        int unsigned         r_now;
        int unsigned         o;
        bit                  emit;
        bit                  top_ok;
        bit                  bot_ok;
        logic [23:0]         pix;
        gbtm_pkg::gbtm_col_t newest;
        mask_word_t          want;
        w = width_reg;
        if (w < 1)
            w = 1;
        if (w > gbtm_pkg::MAX_WIDTH)
            w = gbtm_pkg::MAX_WIDTH;
        h = (height_reg == 0) ? 1 : height_reg;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        c     = col_pos;
        r_now = row_pos;
        // a flushed word enters the window as a black pixel
        pix = flush_in ? 24'd0 : {red_in, green_in, blue_in};
        newest.top    = older_line[c];
        newest.mid    = newer_line[c];
        newest.bot    = pix;
        older_line[c] = newest.mid;
        newer_line[c] = pix;

        emit = 1'b0;
        o    = 0;
        if (c >= 1 && r_now >= 1)
        begin
            o    = r_now - 1;
            emit = (o < h);
        end
        else if (c == 0 && r_now >= 2)
        begin
            o    = r_now - 2;
            emit = (o < h);
        end

        if (emit)
        begin
            sum_r  = 0;
            sum_g  = 0;
            sum_b  = 0;
            top_ok = (o >= 1);
            bot_ok = (o + 1 < h);
            add_column(last_col, 2, top_ok, bot_ok);
            if (c >= 2 || (c == 0 && w >= 2))
                add_column(prev_col, 1, top_ok, bot_ok);
            if (c >= 1)
                add_column(newest, 1, top_ok, bot_ok);
            want.mask      = (sum_r / 16 < red_lim) && (sum_g / 16 < green_lim)
                             && (sum_b / 16 < blue_lim);
            want.row_end   = (c == 0);
            want.frame_end = (c == 0 && o == h - 1);
            expected_masks.push_back(want);
        end

        prev_col = last_col;
        last_col = newest;
        if (c == 0 && r_now >= h + 1)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        else
            col_pos = c + 1;
    endfunction

    // Compare one popped word with the oldest expected mask
    function void check_mask(input mask_word_t got);
        mask_word_t want;
        if (expected_masks.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result word with nothing expected: mask=%0b row_end=%0b frame_end=%0b",
                         got.mask, got.row_end, got.frame_end);
            return;
        end
        want = expected_masks.pop_front();
        if (got.mask !== want.mask || got.row_end !== want.row_end
            || got.frame_end !== want.frame_end)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mask word mismatch: expected mask=%0b row_end=%0b frame_end=%0b, %s",
                         want.mask, want.row_end, want.frame_end,
                         $sformatf("got mask=%0b row_end=%0b frame_end=%0b",
                                   got.mask, got.row_end, got.frame_end));
        end
    endfunction
endclass

module tb_gaussian_blur_threshold_mask;
    import gbtm_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int RANDOM_WORDS = 850;
    localparam int GAP_MAX      = 18;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   push      = 1'b0;
    logic [CH_W-1:0]        red       = '0;
    logic [CH_W-1:0]        green     = '0;
    logic [CH_W-1:0]        blue      = '0;
    logic                   flush     = 1'b0;
    logic                   pop       = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   full;
    logic                   empty;
    logic                   mask;
    logic                   row_end;
    logic                   frame_end;
    logic                   cfg_ready;

    blur_mask_scoreboard masks_sb;
    int                  send_gap_max = GAP_MAX;
    int                  random_words = 0;
    int                  cycle_count  = 0;
    logic                hold_off     = 1'b0;
    logic                pressure_go  = 1'b0;

    gaussian_blur_threshold_mask uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .flush     (flush),
        .empty     (empty),
        .pop       (pop),
        .mask      (mask),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("gaussian_blur_threshold_mask regression: fail");
            $finish;
        end
    end

    // Offer one pixel word after a random gap and hold it until taken
    task automatic send_word(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic f);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        red   <= r;
        green <= g;
        blue  <= b;
        flush <= f;
        do @(posedge clk); while (full);
        masks_sb.take_pixel(r, g, b, f);
    endtask

    // Drain the block, then write all five registers
    task automatic set_up(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                          input logic [CFG_DATA_W-1:0] rl, input logic [CFG_DATA_W-1:0] gl,
                          input logic [CFG_DATA_W-1:0] bl);
        logic [CFG_INDEX_W-1:0] idx [5];
        logic [CFG_DATA_W-1:0]  val [5];
        idx = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_RED_LIMIT, REG_GREEN_LIMIT,
                REG_BLUE_LIMIT};
        val = '{w, h, rl, gl, bl};
        push <= 1'b0;
        while (masks_sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            masks_sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Threshold for a random phase: mostly mid-range, sometimes an extreme
    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'd256;
            2:       return 12'hFFF;
            default: return CFG_DATA_W'($urandom_range(60, 250));
        endcase
    endfunction

    // Send one whole frame plus its drain words; noisy frames mix in flushed
    // pixels and drain words that carry a real colour
    task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
        int unsigned lo [3];
        int unsigned hi [3];
        logic [7:0]  px [3];
        logic        f;
        for (int k = 0; k < 3; k++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                lo[k] = 0;
                hi[k] = 255;
            end
            else
            begin
                lo[k] = $urandom_range(0, 255);
                hi[k] = $urandom_range(lo[k], 255);
            end
        end
        for (int unsigned i = 0; i < w * h; i++)
        begin
            for (int k = 0; k < 3; k++)
                px[k] = 8'($urandom_range(lo[k], hi[k]));
            f = noisy && ($urandom_range(0, 15) == 0);
            send_word(px[0], px[1], px[2], f);
        end
        for (int unsigned i = 0; i <= w; i++)
        begin
            f = noisy ? ($urandom_range(0, 3) != 0) : 1'b1;
            send_word(8'($urandom), 8'($urandom), 8'($urandom), f);
        end
    endtask

    // Pop result words with random stalls, holding off while asked
    initial
    begin : result_side
        int         gap;
        int         taken;
        int         take_gap_max;
        mask_word_t got;
        taken        = 0;
        take_gap_max = GAP_MAX;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            gap = $urandom_range(0, take_gap_max);
            if (gap > 0 || hold_off)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got.mask      = mask;
            got.row_end   = row_end;
            got.frame_end = frame_end;
            masks_sb.check_mask(got);
            taken++;
        end
    end

    // Stall the result side for long stretches so the input backs up
    initial
    begin : result_hold
        wait (pressure_go === 1'b1);
        repeat (2)
        begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
            repeat (6000) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] wr;
        logic [CFG_DATA_W-1:0] hr;
        int unsigned           w;
        int unsigned           h;
        masks_sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame at the reset limits: extremes, a flushed pixel with colour,
        // and a drain word that carries a colour
        set_up(12'd3, 12'd3, CFG_DATA_W'(RST_RED_LIMIT), CFG_DATA_W'(RST_GREEN_LIMIT),
               CFG_DATA_W'(RST_BLUE_LIMIT));
        send_word(8'd255, 8'd255, 8'd255, 1'b0);
        send_word(8'd0, 8'd0, 8'd0, 1'b0);
        send_word(8'd255, 8'd0, 8'd128, 1'b0);
        send_word(8'd0, 8'd255, 8'd0, 1'b0);
        send_word(8'd255, 8'd255, 8'd255, 1'b1);
        send_word(8'd0, 8'd0, 8'd255, 1'b0);
        send_word(8'd128, 8'd128, 8'd128, 1'b0);
        send_word(8'd255, 8'd255, 8'd0, 1'b0);
        send_word(8'd0, 8'd0, 8'd0, 1'b0);
        send_word(8'd0, 8'd0, 8'd0, 1'b1);
        send_word(8'd0, 8'd0, 8'd0, 1'b1);
        send_word(8'd255, 8'd255, 8'd255, 1'b0);
        send_word(8'd0, 8'd0, 8'd0, 1'b1);

        // zero width and height act as a single pixel; limits of 256 always pass
        set_up(12'd0, 12'd0, 12'd256, 12'd256, 12'd256);
        send_word(8'd255, 8'd255, 8'd255, 1'b0);
        send_word(8'd0, 8'd0, 8'd0, 1'b1);
        send_word(8'd0, 8'd0, 8'd0, 1'b1);

        // zero limits never pass
        set_up(12'd2, 12'd2, 12'd0, 12'd0, 12'd0);
        send_word(8'd255, 8'd255, 8'd255, 1'b0);
        send_word(8'd0, 8'd0, 8'd0, 1'b0);
        send_word(8'd0, 8'd0, 8'd0, 1'b0);
        send_word(8'd255, 8'd255, 8'd255, 1'b0);
        send_word(8'd0, 8'd0, 8'd0, 1'b1);
        send_word(8'd0, 8'd0, 8'd0, 1'b1);
        send_word(8'd0, 8'd0, 8'd0, 1'b1);

        // random phases of small frames
        pressure_go <= 1'b1;
        while (random_words < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 19))
                0:       wr = 12'd0;
                1, 2, 3: wr = CFG_DATA_W'($urandom_range(9, 40));
                default: wr = CFG_DATA_W'($urandom_range(1, 8));
            endcase
            hr = ($urandom_range(0, 19) == 0) ? 12'd0 : CFG_DATA_W'($urandom_range(1, 6));
            set_up(wr, hr, pick_limit(), pick_limit(), pick_limit());
            w = (wr == 0) ? 1 : wr;
            h = (hr == 0) ? 1 : hr;
            repeat ($urandom_range(1, 3))
            begin
                send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
                send_frame(w, h, $urandom_range(0, 3) == 0);
                random_words += w * h + w + 1;
            end
        end

        // one wide single-row frame and one tall single-column frame
        send_gap_max = GAP_MAX;
        set_up(12'd256, 12'd1, pick_limit(), pick_limit(), pick_limit());
        send_frame(256, 1, 1'b0);
        set_up(12'd1, 12'd200, pick_limit(), pick_limit(), pick_limit());
        send_frame(1, 200, 1'b0);

        // wait out the tail, then report
        push <= 1'b0;
        while (masks_sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (masks_sb.mismatches == 0)
            $display("gaussian_blur_threshold_mask regression: pass");
        else
            $display("gaussian_blur_threshold_mask regression: fail");
        $finish;
    end

endmodule

>>> files.f
sv/gbtm_pkg.sv
sv/gbtm_ram.sv
sv/gbtm_front.sv
sv/gbtm_fifo.sv
sv/gbtm_back.sv
sv/gaussian_blur_threshold_mask.sv
verif/tb_gaussian_blur_threshold_mask.sv
